### rtl/prl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// prl_pkg
// shared constants for the pointer report rate limiter: sizes, register
// indexes and register reset values
// ----------------------------------------------------------------------------
package prl_pkg;

    localparam int CHANNELS  = 4;
    localparam int TIME_BITS = 40;
    localparam int CODE_REGS = 4;

    localparam int KIND_W  = 8;
    localparam int CODE_W  = 16;
    localparam int VALUE_W = 32;
    localparam int SUM_W   = 16;
    localparam int DELAY_W = 8;
    localparam int COUNT_W = 3;
    localparam int GAP_SHIFT = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DELAY      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_KIND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SLOT0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SLOT1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SLOT2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_SLOT3 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LIMITER_ON = 3'd7;

    localparam logic [DELAY_W-1:0] DELAY_RESET      = 8'd8;
    localparam logic [KIND_W-1:0]  MATCH_KIND_RESET = 8'd2;
    localparam logic [COUNT_W-1:0] CODE_COUNT_RESET = 3'd0;

endpackage
`default_nettype wire

### rtl/pointer_report_rate_limiter.sv
`default_nettype none
// pipeline: 2 register stages; an accepted item waits in the input register and moves on
//   into the result register once that is free or being emptied, and leaves from there
// throughput: one item per cycle while the receiver takes results; the per-channel state
//   is read combinationally from the input register and updated as the item moves on
// reset: asynchronous, active low; configuration registers take their default values, all channel
//   sums, sync flags and report stamps clear to zero
// ----------------------------------------------------------------------------
// pointer_report_rate_limiter
// per-code rate limiter for relative pointer events with pending value merge
// ----------------------------------------------------------------------------
module pointer_report_rate_limiter #(
    parameter int CHANNELS  = prl_pkg::CHANNELS,
    parameter int TIME_BITS = prl_pkg::TIME_BITS,
    localparam int IN_BITS  = prl_pkg::KIND_W + prl_pkg::CODE_W + prl_pkg::VALUE_W
                              + TIME_BITS,
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,

    input  wire logic                             cfg_we,
    input  wire logic [prl_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [prl_pkg::CFG_DATA_W-1:0]   cfg_data,

    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // event_kind, event_code, event_value, now_ms, zero fill
    input  wire logic [IN_W-1:0]                  s_tdata,
    // event_sync
    input  wire logic                             s_tlast,

    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // out_value
    output logic [prl_pkg::VALUE_W-1:0]           m_tdata,
    // out_sync
    output logic                                  m_tlast,
    // forward
    output logic                                  m_tuser
);

    localparam int KIND_LO  = 0;
    localparam int CODE_LO  = KIND_LO + prl_pkg::KIND_W;
    localparam int VALUE_LO = CODE_LO + prl_pkg::CODE_W;
    localparam int TIME_LO  = VALUE_LO + prl_pkg::VALUE_W;
    localparam int ACC_W    = prl_pkg::VALUE_W + 2;

    // configuration registers
    logic [prl_pkg::DELAY_W-1:0]  delay_reg;
    logic [prl_pkg::KIND_W-1:0]   match_kind_reg;
    logic [prl_pkg::COUNT_W-1:0]  code_count_reg;
    logic [prl_pkg::CODE_W-1:0]   code_slot_reg [prl_pkg::CODE_REGS];
    logic                         limiter_on_reg;

    // channel state
    logic signed [prl_pkg::SUM_W-1:0] sum_reg  [CHANNELS];
    logic                             sync_reg [CHANNELS];
    logic [TIME_BITS-1:0]             last_reg [CHANNELS];

    // input register
    logic                             in_valid_reg;
    logic [prl_pkg::KIND_W-1:0]       in_kind_reg;
    logic [prl_pkg::CODE_W-1:0]       in_code_reg;
    logic signed [prl_pkg::VALUE_W-1:0] in_value_reg;
    logic                             in_sync_reg;
    logic [TIME_BITS-1:0]             in_now_reg;

    // result register
    logic                             out_valid_reg;
    logic [prl_pkg::VALUE_W-1:0]      out_value_reg;
    logic                             out_sync_reg;
    logic                             out_fwd_reg;

    logic                             advance;
    logic                             kind_ok;
    logic [CHANNELS-1:0]              hit;
    logic [CHANNELS-1:0]              sel;
    logic                             found;
    logic                             limited;
    logic signed [prl_pkg::SUM_W-1:0] sel_sum;
    logic                             sel_sync;
    logic [TIME_BITS-1:0]             sel_last;
    logic [TIME_BITS-1:0]             elapsed;
    logic                             expired;
    logic                             inside_win;
    logic                             suppress;
    logic signed [prl_pkg::SUM_W-1:0] base_sum;
    logic                             base_sync;
    logic signed [ACC_W-1:0]          acc;
    logic signed [prl_pkg::SUM_W-1:0] sum_next;
    logic [prl_pkg::VALUE_W-1:0]      merged;
    logic [prl_pkg::VALUE_W-1:0]      out_value_next;
    logic                             out_sync_next;
    logic                             out_fwd_next;
    logic                             clear_all;

    localparam logic signed [ACC_W-1:0] S16_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] S16_MIN = -ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(64'sd2147483647);
    localparam logic signed [ACC_W-1:0] S32_MIN = -ACC_W'(64'sd2147483648);

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign kind_ok  = limiter_on_reg && (in_kind_reg == match_kind_reg);
    assign clear_all = cfg_we && (cfg_index == prl_pkg::REG_LIMITER_ON) && !cfg_data[0];

    // code compare per channel
    for (genvar i = 0; i < CHANNELS; i++) begin : g_hit
        if (i < prl_pkg::CODE_REGS) begin : g_slot
            assign hit[i] = kind_ok && (32'(code_count_reg) > i)
                            && (code_slot_reg[i] == in_code_reg);
        end else begin : g_none
            assign hit[i] = 1'b0;
        end
    end

    // lowest matching slot wins
    always_comb
    begin
        found = 1'b0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            sel[i] = hit[i] && !found;
            found  = found || hit[i];
        end
    end

    always_comb
    begin
        sel_sum  = '0;
        sel_sync = 1'b0;
        sel_last = '0;
        for (int i = 0; i < CHANNELS; i++)
        begin
            if (sel[i])
            begin
                sel_sum  = sel_sum | sum_reg[i];
                sel_sync = sel_sync | sync_reg[i];
                sel_last = sel_last | last_reg[i];
            end
        end
    end

    assign limited    = |sel;
    assign elapsed    = in_now_reg - sel_last;
    assign expired    = elapsed >= TIME_BITS'({delay_reg, {prl_pkg::GAP_SHIFT{1'b0}}});
    assign inside_win = elapsed < TIME_BITS'(delay_reg);
    assign suppress   = limited && inside_win;
    assign base_sum   = expired ? '0 : sel_sum;
    assign base_sync  = expired ? 1'b0 : sel_sync;
    assign acc        = ACC_W'(in_value_reg) + ACC_W'(base_sum);

    always_comb
    begin
        if (acc > S16_MAX)
            sum_next = prl_pkg::SUM_W'(S16_MAX);
        else if (acc < S16_MIN)
            sum_next = prl_pkg::SUM_W'(S16_MIN);
        else
            sum_next = acc[prl_pkg::SUM_W-1:0];

        if (acc > S32_MAX)
            merged = prl_pkg::VALUE_W'(S32_MAX);
        else if (acc < S32_MIN)
            merged = prl_pkg::VALUE_W'(S32_MIN);
        else
            merged = acc[prl_pkg::VALUE_W-1:0];
    end

    always_comb
    begin
        if (suppress)
        begin
            out_fwd_next   = 1'b0;
            out_value_next = '0;
            out_sync_next  = 1'b0;
        end
        else if (limited)
        begin
            out_fwd_next   = 1'b1;
            out_value_next = merged;
            out_sync_next  = in_sync_reg || base_sync;
        end
        else
        begin
            out_fwd_next   = 1'b1;
            out_value_next = in_value_reg;
            out_sync_next  = in_sync_reg;
        end
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg      <= prl_pkg::DELAY_RESET;
            match_kind_reg <= prl_pkg::MATCH_KIND_RESET;
            code_count_reg <= prl_pkg::CODE_COUNT_RESET;
            for (int i = 0; i < prl_pkg::CODE_REGS; i++)
                code_slot_reg[i] <= '0;
            limiter_on_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                prl_pkg::REG_DELAY:      delay_reg      <= cfg_data[prl_pkg::DELAY_W-1:0];
                prl_pkg::REG_MATCH_KIND: match_kind_reg <= cfg_data[prl_pkg::KIND_W-1:0];
                prl_pkg::REG_CODE_COUNT: code_count_reg <= cfg_data[prl_pkg::COUNT_W-1:0];
                prl_pkg::REG_CODE_SLOT0: code_slot_reg[0] <= cfg_data;
                prl_pkg::REG_CODE_SLOT1: code_slot_reg[1] <= cfg_data;
                prl_pkg::REG_CODE_SLOT2: code_slot_reg[2] <= cfg_data;
                prl_pkg::REG_CODE_SLOT3: code_slot_reg[3] <= cfg_data;
                prl_pkg::REG_LIMITER_ON: limiter_on_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // channel state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]  <= '0;
                sync_reg[i] <= 1'b0;
                last_reg[i] <= '0;
            end
        end
        else if (clear_all)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                sum_reg[i]  <= '0;
                sync_reg[i] <= 1'b0;
            end
        end
        else if (advance)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                if (sel[i])
                begin
                    if (inside_win)
                    begin
                        sum_reg[i]  <= sum_next;
                        sync_reg[i] <= base_sync || in_sync_reg;
                    end
                    else
                    begin
                        sum_reg[i]  <= '0;
                        sync_reg[i] <= 1'b0;
                        last_reg[i] <= in_now_reg;
                    end
                end
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_kind_reg  <= s_tdata[KIND_LO +: prl_pkg::KIND_W];
            in_code_reg  <= s_tdata[CODE_LO +: prl_pkg::CODE_W];
            in_value_reg <= s_tdata[VALUE_LO +: prl_pkg::VALUE_W];
            in_now_reg   <= s_tdata[TIME_LO +: TIME_BITS];
            in_sync_reg  <= s_tlast;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_value_reg <= out_value_next;
            out_sync_reg  <= out_sync_next;
            out_fwd_reg   <= out_fwd_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tlast  = out_sync_reg;
    assign m_tuser  = out_fwd_reg;

`ifndef SYNTHESIS
    a_suppressed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> (m_tdata == '0) && !m_tlast)
        else $error("suppressed item carries nonzero value or sync");

    a_bypass_forwards: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !limiter_on_reg |=> m_tvalid && m_tuser)
        else $error("item suppressed while limiter is off");

    a_one_channel: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg |-> $onehot0(sel))
        else $error("more than one channel selected");
`endif

endmodule
`default_nettype wire

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the pointer report rate limiter: a directed table
// covers the saturation, window, long-gap, wrap, duplicate-code and bypass
// cases, then random settings phases drive per-code event streams with
// random idling on both stream sides and checks every result against a
// cycle-free behavioral predictor
// ----------------------------------------------------------------------------
module testbench;

    localparam int EV_BITS = prl_pkg::KIND_W + prl_pkg::CODE_W + prl_pkg::VALUE_W
                             + prl_pkg::TIME_BITS;
    localparam int EV_W    = ((EV_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 1700;

    localparam longint SUM_LO = -(longint'(1) << (prl_pkg::SUM_W - 1));
    localparam longint SUM_HI = (longint'(1) << (prl_pkg::SUM_W - 1)) - 1;
    localparam longint VAL_LO = -(longint'(1) << (prl_pkg::VALUE_W - 1));
    localparam longint VAL_HI = (longint'(1) << (prl_pkg::VALUE_W - 1)) - 1;

    localparam logic signed [prl_pkg::VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [prl_pkg::VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;
    localparam logic [prl_pkg::TIME_BITS-1:0] TIME_TOP = '1;

    typedef struct {
        logic [prl_pkg::KIND_W-1:0]         kind;
        logic [prl_pkg::CODE_W-1:0]         code;
        logic signed [prl_pkg::VALUE_W-1:0] value;
        logic                               sync;
        logic [prl_pkg::TIME_BITS-1:0]      now;
    } ptr_event_t;

    typedef struct {
        logic                               fwd;
        logic signed [prl_pkg::VALUE_W-1:0] value;
        logic                               sync;
    } report_t;

    typedef struct {
        bit                               is_write;
        logic [prl_pkg::CFG_IDX_W-1:0]    idx;
        logic [prl_pkg::CFG_DATA_W-1:0]   data;
        ptr_event_t                       ev;
        bit                               typed;
        report_t                          want;
    } stim_row_t;

    logic                                 clk;
    logic                                 rst_n;
    logic                                 cfg_we;
    logic [prl_pkg::CFG_IDX_W-1:0]        cfg_index;
    logic [prl_pkg::CFG_DATA_W-1:0]       cfg_data;
    logic                                 s_tvalid;
    logic                                 s_tready;
    logic [EV_W-1:0]                      s_tdata;
    logic                                 s_tlast;
    logic                                 m_tvalid;
    logic                                 m_tready;
    logic [prl_pkg::VALUE_W-1:0]          m_tdata;
    logic                                 m_tlast;
    logic                                 m_tuser;

    // predictor copy of the registers
    logic [prl_pkg::DELAY_W-1:0]  window_ms       = prl_pkg::DELAY_RESET;
    logic [prl_pkg::KIND_W-1:0]   tracked_kind    = prl_pkg::MATCH_KIND_RESET;
    logic [prl_pkg::COUNT_W-1:0]  slots_in_use    = prl_pkg::CODE_COUNT_RESET;
    logic [prl_pkg::CODE_W-1:0]   slot_code [prl_pkg::CODE_REGS] = '{default: '0};
    logic                         limiter_enabled = 1'b1;

    // predictor copy of the channel state
    logic signed [prl_pkg::SUM_W-1:0] held_sum [prl_pkg::CHANNELS]         = '{default: '0};
    logic                             held_sync [prl_pkg::CHANNELS]        = '{default: 1'b0};
    logic [prl_pkg::TIME_BITS-1:0]    report_stamp [prl_pkg::CHANNELS]     = '{default: '0};

    report_t                     expected_reports [$];
    stim_row_t                   directed_rows [$];

    int mismatches     = 0;
    int events_sent    = 0;
    int reports_seen   = 0;
    int forwarded      = 0;
    int held_back      = 0;
    int settings_used  = 0;
    int input_stalls   = 0;
    int longest_hold   = 0;
    int rx_hold        = 0;
    bit tx_calm        = 1'b0;
    bit rx_calm        = 1'b0;

    pointer_report_rate_limiter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d reports outstanding", expected_reports.size());
        $display("pointer_report_rate_limiter regression: fail");
        $finish;
    end

    function automatic void apply_reg(input logic [prl_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [prl_pkg::CFG_DATA_W-1:0] data);
        int i;
        case (idx)
            prl_pkg::REG_DELAY:      window_ms    = data[prl_pkg::DELAY_W-1:0];
            prl_pkg::REG_MATCH_KIND: tracked_kind = data[prl_pkg::KIND_W-1:0];
            prl_pkg::REG_CODE_COUNT: slots_in_use = data[prl_pkg::COUNT_W-1:0];
            prl_pkg::REG_CODE_SLOT0: slot_code[0] = data[prl_pkg::CODE_W-1:0];
            prl_pkg::REG_CODE_SLOT1: slot_code[1] = data[prl_pkg::CODE_W-1:0];
            prl_pkg::REG_CODE_SLOT2: slot_code[2] = data[prl_pkg::CODE_W-1:0];
            prl_pkg::REG_CODE_SLOT3: slot_code[3] = data[prl_pkg::CODE_W-1:0];
            prl_pkg::REG_LIMITER_ON:
            begin
                limiter_enabled = data[0];
                if (!data[0])
                    for (i = 0; i < prl_pkg::CHANNELS; i++)
                    begin
                        held_sum[i]  = '0;
                        held_sync[i] = 1'b0;
                    end
            end
            default: ;
        endcase
    endfunction

    function automatic report_t predict_report(input ptr_event_t ev);
        report_t r;
        int ch;
        int used;
        int i;
        logic [prl_pkg::TIME_BITS-1:0] elapsed;
        longint merged;
        ch = -1;
        used = (slots_in_use > prl_pkg::CODE_REGS) ? prl_pkg::CODE_REGS : slots_in_use;
        if (used > prl_pkg::CHANNELS)
            used = prl_pkg::CHANNELS;
        // lowest matching slot wins
        if (limiter_enabled && ev.kind == tracked_kind)
            for (i = used - 1; i >= 0; i--)
                if (slot_code[i] == ev.code)
                    ch = i;
        r.fwd   = 1'b1;
        r.value = ev.value;
        r.sync  = ev.sync;
        if (ch >= 0)
        begin
            elapsed = ev.now - report_stamp[ch];
            if (elapsed >= {window_ms, 2'b00})
            begin
                held_sum[ch]  = '0;
                held_sync[ch] = 1'b0;
            end
            if (elapsed < window_ms)
            begin
                merged = longint'(held_sum[ch]) + longint'(ev.value);
                held_sum[ch] = prl_pkg::SUM_W'((merged < SUM_LO) ? SUM_LO
                             : (merged > SUM_HI) ? SUM_HI : merged);
                held_sync[ch] = held_sync[ch] | ev.sync;
                r.fwd   = 1'b0;
                r.value = '0;
                r.sync  = 1'b0;
            end
            else
            begin
                merged = longint'(ev.value) + longint'(held_sum[ch]);
                r.value = prl_pkg::VALUE_W'((merged < VAL_LO) ? VAL_LO
                        : (merged > VAL_HI) ? VAL_HI : merged);
                r.sync  = ev.sync | held_sync[ch];
                held_sum[ch]  = '0;
                held_sync[ch] = 1'b0;
                report_stamp[ch] = ev.now;
            end
        end
        return r;
    endfunction

    function automatic void add_write(input logic [prl_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [prl_pkg::CFG_DATA_W-1:0] data);
        stim_row_t row;
        row = '{default: '0};
        row.is_write = 1'b1;
        row.idx      = idx;
        row.data     = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_event(input logic [prl_pkg::KIND_W-1:0] k,
                                      input logic [prl_pkg::CODE_W-1:0] c,
                                      input logic signed [prl_pkg::VALUE_W-1:0] v,
                                      input logic s,
                                      input logic [prl_pkg::TIME_BITS-1:0] n);
        stim_row_t row;
        row = '{default: '0};
        row.ev = '{k, c, v, s, n};
        directed_rows.push_back(row);
    endfunction

    function automatic void add_checked(input logic [prl_pkg::KIND_W-1:0] k,
                                        input logic [prl_pkg::CODE_W-1:0] c,
                                        input logic signed [prl_pkg::VALUE_W-1:0] v,
                                        input logic s,
                                        input logic [prl_pkg::TIME_BITS-1:0] n,
                                        input logic f,
                                        input logic signed [prl_pkg::VALUE_W-1:0] ov,
                                        input logic os);
        stim_row_t row;
        row = '{default: '0};
        row.ev    = '{k, c, v, s, n};
        row.typed = 1'b1;
        row.want  = '{f, ov, os};
        directed_rows.push_back(row);
    endfunction

    task automatic report_mismatch(input string what, input longint want, input longint got);
        $display("mismatch on %s at report %0d: expected %0d got %0d",
                 what, reports_seen, want, got);
        mismatches++;
    endtask

    task automatic write_reg(input logic [prl_pkg::CFG_IDX_W-1:0] idx,
                             input logic [prl_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_reg(idx, data);
        @(negedge clk);
    endtask

    // stop offering and wait until every expected report is back
    task automatic drain();
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_event(input ptr_event_t ev, input bit typed, input report_t want);
        int gap;
        report_t r;
        gap = tx_calm ? 0 : $urandom_range(0, 3);
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  <= EV_W'({ev.now, ev.value, ev.code, ev.kind});
        s_tlast  <= ev.sync;
        s_tvalid <= 1'b1;
        do
        begin
            @(posedge clk);
            if (!s_tready)
                input_stalls++;
        end
        while (!s_tready);
        r = predict_report(ev);
        expected_reports.push_back(typed ? want : r);
        events_sent++;
        @(negedge clk);
    endtask

    task automatic random_settings(input int phase);
        logic [prl_pkg::CFG_DATA_W-1:0] d;
        logic [prl_pkg::CODE_W-1:0] codes [prl_pkg::CODE_REGS];
        int i;
        case ($urandom_range(0, 7))
            0: d = '0;
            1: d = 16'd255;
            2: d = 16'd1;
            3: d = prl_pkg::CFG_DATA_W'($urandom());
            default: d = prl_pkg::CFG_DATA_W'($urandom_range(2, 40));
        endcase
        if (phase < 2)
            d = (phase != 0) ? 16'd255 : 16'd0;
        write_reg(prl_pkg::REG_DELAY, d);
        case ($urandom_range(0, 4))
            0: d = '0;
            1: d = 16'd255;
            2: d = prl_pkg::CFG_DATA_W'($urandom());
            default: d = prl_pkg::CFG_DATA_W'($urandom_range(0, 255));
        endcase
        write_reg(prl_pkg::REG_MATCH_KIND, d);
        d = prl_pkg::CFG_DATA_W'($urandom_range(0, 7));
        if ($urandom_range(0, 7) == 0)
            d = d | prl_pkg::CFG_DATA_W'($urandom() & 16'hfff8);
        write_reg(prl_pkg::REG_CODE_COUNT, d);
        for (i = 0; i < prl_pkg::CODE_REGS; i++)
        begin
            case ($urandom_range(0, 5))
                0: codes[i] = '0;
                1: codes[i] = '1;
                2: codes[i] = (i > 0) ? codes[$urandom_range(0, i - 1)] : 16'h0001;
                default: codes[i] = prl_pkg::CODE_W'($urandom());
            endcase
            write_reg(prl_pkg::REG_CODE_SLOT0 + prl_pkg::CFG_IDX_W'(i), codes[i]);
        end
        if ($urandom_range(0, 3) == 0)
            write_reg(prl_pkg::REG_LIMITER_ON, 16'h0000);
        d = prl_pkg::CFG_DATA_W'($urandom_range(0, 5) != 0);
        if ($urandom_range(0, 7) == 0)
            d = d | prl_pkg::CFG_DATA_W'($urandom() & 16'hfffe);
        write_reg(prl_pkg::REG_LIMITER_ON, d);
        settings_used++;
    endtask

    // receiver side: per-item stalls, plus long hold-offs on request
    initial
    begin
        int w;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            w = rx_calm ? 0 : $urandom_range(0, 3);
            if (rx_hold > 0)
            begin
                w = rx_hold;
                if (rx_hold > longest_hold)
                    longest_hold = rx_hold;
                rx_hold = 0;
            end
            if (w > 0)
            begin
                m_tready <= 1'b0;
                repeat (w) @(negedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_reports.size() == 0)
                report_mismatch("unexpected report value", 0, $signed(m_tdata));
            else
            begin
                want = expected_reports.pop_front();
                if (m_tuser !== want.fwd)
                    report_mismatch("forward", want.fwd, m_tuser);
                if (m_tdata !== want.value)
                    report_mismatch("out_value", want.value, $signed(m_tdata));
                if (m_tlast !== want.sync)
                    report_mismatch("out_sync", want.sync, m_tlast);
            end
            if (m_tuser)
                forwarded++;
            else
                held_back++;
            reports_seen++;
        end
    end

    initial
    begin
        ptr_event_t ev;
        stim_row_t row;
        logic [prl_pkg::TIME_BITS-1:0] clock_ms;
        int phase;
        int n;
        int k;
        int span;
        int random_sent;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = prl_pkg::REG_DELAY;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;

        // reset settings: no code slots in use, so everything passes
        add_checked(8'd2, 16'h0000, 5, 1'b0, 0, 1'b1, 5, 1'b0);
        add_checked(8'd255, 16'hffff, VALUE_MIN, 1'b1, TIME_TOP, 1'b1, VALUE_MIN, 1'b1);
        add_checked(8'd0, 16'h0000, VALUE_MAX, 1'b0, 0, 1'b1, VALUE_MAX, 1'b0);
        add_write(prl_pkg::REG_CODE_COUNT, 16'd2);
        add_write(prl_pkg::REG_CODE_SLOT0, 16'h0000);
        add_write(prl_pkg::REG_CODE_SLOT1, 16'hffff);
        // window suppression with 16-bit saturation both ways
        add_checked(8'd2, 16'h0000, 100, 1'b0, 0, 1'b0, 0, 1'b0);
        add_checked(8'd2, 16'h0000, 32767, 1'b1, 1, 1'b0, 0, 1'b0);
        add_checked(8'd2, 16'h0000, 1, 1'b0, 8, 1'b1, 32768, 1'b1);
        add_checked(8'd2, 16'h0000, -32768, 1'b0, 9, 1'b0, 0, 1'b0);
        add_checked(8'd2, 16'h0000, -5, 1'b0, 10, 1'b0, 0, 1'b0);
        add_checked(8'd2, 16'h0000, VALUE_MIN, 1'b0, 16, 1'b1, VALUE_MIN, 1'b0);
        // long gap drops the pending sum
        add_checked(8'd2, 16'h0000, 50, 1'b1, 17, 1'b0, 0, 1'b0);
        add_checked(8'd2, 16'h0000, 7, 1'b0, 48, 1'b1, 7, 1'b0);
        // time wrap and 32-bit saturation
        add_checked(8'd2, 16'hffff, 9, 1'b0, TIME_TOP - 2, 1'b1, 9, 1'b0);
        add_checked(8'd2, 16'hffff, VALUE_MAX, 1'b1, 2, 1'b0, 0, 1'b0);
        add_checked(8'd2, 16'hffff, VALUE_MAX, 1'b0, 4, 1'b0, 0, 1'b0);
        add_checked(8'd2, 16'hffff, VALUE_MAX, 1'b0, 5, 1'b1, VALUE_MAX, 1'b1);
        // other kind, unused code
        add_checked(8'd3, 16'h0000, -1, 1'b1, 49, 1'b1, -1, 1'b1);
        add_checked(8'd2, 16'h1234, 11, 1'b0, 50, 1'b1, 11, 1'b0);
        // oversized count and duplicate codes
        add_write(prl_pkg::REG_CODE_COUNT, 16'd7);
        add_write(prl_pkg::REG_CODE_SLOT2, 16'h1234);
        add_write(prl_pkg::REG_CODE_SLOT3, 16'h1234);
        add_event(8'd2, 16'h1234, 20, 1'b0, 60);
        add_event(8'd2, 16'h1234, 30, 1'b1, 61);
        add_event(8'd2, 16'h1234, 40, 1'b0, 68);
        // zero delay, widest delay, bypass
        add_write(prl_pkg::REG_DELAY, 16'd0);
        add_event(8'd2, 16'h0000, 3, 1'b0, 48);
        add_write(prl_pkg::REG_DELAY, 16'd255);
        add_write(prl_pkg::REG_MATCH_KIND, 16'd255);
        add_event(8'd255, 16'h0000, 4, 1'b0, 100);
        add_write(prl_pkg::REG_LIMITER_ON, 16'd0);
        add_checked(8'd255, 16'h0000, 6, 1'b0, 101, 1'b1, 6, 1'b0);
        add_write(prl_pkg::REG_LIMITER_ON, 16'd1);
        add_event(8'd255, 16'h0000, 8, 1'b1, 303);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            if (row.is_write)
            begin
                drain();
                write_reg(row.idx, row.data);
            end
            else
                send_event(row.ev, row.typed, row.want);
        end

        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            drain();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            random_settings(phase);
            if (phase == 1 || $urandom_range(0, 4) == 0)
            begin
                tx_calm = 1'b1;
                rx_hold = $urandom_range(30, 80);
            end
            if ($urandom_range(0, 3) == 0)
                clock_ms = TIME_TOP - prl_pkg::TIME_BITS'($urandom_range(0, 600));
            else
                clock_ms = {8'($urandom()), 32'($urandom())};
            span = (window_ms < 2) ? 2 : window_ms;
            n = $urandom_range(40, 110);
            for (k = 0; k < n; k++)
            begin
                if ($urandom_range(0, 59) == 0)
                    drain();
                case ($urandom_range(0, 19))
                    0:       clock_ms = {8'($urandom()), 32'($urandom())};
                    1, 2:    clock_ms = clock_ms
                                        + prl_pkg::TIME_BITS'($urandom_range(0, 5 * span));
                    default: clock_ms = clock_ms
                                        + prl_pkg::TIME_BITS'($urandom_range(0, span));
                endcase
                ev.now  = clock_ms;
                ev.kind = ($urandom_range(0, 6) != 0) ? tracked_kind
                                                      : prl_pkg::KIND_W'($urandom());
                ev.code = ($urandom_range(0, 6) != 0)
                          ? slot_code[$urandom_range(0, prl_pkg::CODE_REGS - 1)]
                          : prl_pkg::CODE_W'($urandom());
                ev.sync = 1'($urandom_range(0, 1));
                case ($urandom_range(0, 19))
                    0:  ev.value = VALUE_MIN;
                    1:  ev.value = VALUE_MAX;
                    2:  ev.value = -1;
                    3:  ev.value = prl_pkg::VALUE_W'(SUM_HI);
                    4:  ev.value = prl_pkg::VALUE_W'(SUM_LO);
                    5, 6, 7:   ev.value = $urandom();
                    8, 9, 10:  ev.value = $signed($urandom_range(0, 60000)) - 30000;
                    default:   ev.value = $signed($urandom_range(0, 1000)) - 500;
                endcase
                send_event(ev, 1'b0, '{default: '0});
                random_sent++;
            end
            phase++;
        end

        s_tvalid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("%0d events over %0d random settings plus directed cases: %0d forwarded, %0d held",
                 events_sent, settings_used, forwarded, held_back);
        $display("receiver hold-off up to %0d cycles, input stalled %0d cycles",
                 longest_hold, input_stalls);
        if (mismatches == 0 && expected_reports.size() == 0)
            $display("pointer_report_rate_limiter regression: pass");
        else
            $display("pointer_report_rate_limiter regression: fail");
        $finish;
    end

endmodule
